FILE: rtl/tlsm_pkg.sv
// package for the two-list sorted merge block
// request types, controller/datapath command and status structs, fsm states
// no dependencies
`default_nettype none

package tlsm_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int EFF_WIDTH   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int SEXT_SHIFT  = 32 - EFF_WIDTH;
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               list_id;
    logic               is_last;
    logic               is_empty;
  } in_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_MERGE,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic pick;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic has_err;
    logic pick_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/tlsm_ctrl.sv
// controller fsm for the two-list sorted merge block
// sequences load, merge and error phases; uses tlsm_pkg
`default_nettype none

module tlsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tlsm_pkg::sts_t sts,
  output tlsm_pkg::cmd_t     cmd
);
  import tlsm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        cmd.accept_en = 1'b1;
        if (sts.complete) begin
          state_next = sts.has_err ? ST_ERR : ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.pick = sts.out_free;
        if (sts.out_free && sts.pick_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_ERR: begin
        cmd.emit_err = sts.out_free;
        if (sts.out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tlsm_dp.sv
// datapath for the two-list sorted merge block
// list buffers, counts, merge pointers and output register; uses tlsm_pkg
`default_nettype none

module tlsm_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire tlsm_pkg::in_t  in_data,
  output tlsm_pkg::out_t      out_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire tlsm_pkg::cmd_t cmd,
  output tlsm_pkg::sts_t      sts
);
  import tlsm_pkg::*;

  logic signed [31:0] buf_a [LIST_DEPTH];
  logic signed [31:0] buf_b [LIST_DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  logic [CNT_W-1:0] cnt_a, cnt_a_next;
  logic [CNT_W-1:0] cnt_b, cnt_b_next;
  logic [CNT_W-1:0] ia, ia_next;
  logic [CNT_W-1:0] jb, jb_next;
  logic             done_a, done_a_next;
  logic             done_b, done_b_next;
  logic [1:0]       err, err_next;

  logic               take;
  logic               store;
  logic [CNT_W-1:0]   cnt_sel;
  logic signed [31:0] value_ext;
  logic signed [31:0] value_sh;
  logic               has_a, has_b, take_a;
  logic signed [31:0] pick_value;
  logic               clear;

  always_comb begin
    value_sh  = in_data.value <<< SEXT_SHIFT;
    value_ext = value_sh >>> SEXT_SHIFT;
  end

  assign cnt_sel = in_data.list_id ? cnt_b : cnt_a;
  assign take    = cmd.accept_en && in_valid && !(in_data.list_id ? done_b : done_a);
  assign store   = take && !in_data.is_empty && (cnt_sel < CNT_W'(LIST_DEPTH));

  assign has_a  = ia < cnt_a;
  assign has_b  = jb < cnt_b;
  assign take_a = has_a && (!has_b || (rd_a < rd_b));
  assign pick_value = take_a ? rd_a : rd_b;

  assign clear = (cmd.pick && sts.pick_last) || cmd.emit_err;

  always_comb begin
    cnt_a_next  = cnt_a;
    cnt_b_next  = cnt_b;
    done_a_next = done_a;
    done_b_next = done_b;
    err_next    = err;
    ia_next     = ia;
    jb_next     = jb;
    if (take) begin
      if (in_data.is_empty) begin
        err_next = STATUS_EMPTY;
        if (in_data.list_id) done_b_next = 1'b1;
        else                 done_a_next = 1'b1;
      end else begin
        if (store) begin
          if (in_data.list_id) cnt_b_next = cnt_b + 1'b1;
          else                 cnt_a_next = cnt_a + 1'b1;
        end else if (err == STATUS_OK) begin
          err_next = STATUS_OVERFLOW;
        end
        if (in_data.is_last) begin
          if (in_data.list_id) done_b_next = 1'b1;
          else                 done_a_next = 1'b1;
        end
      end
    end
    if (cmd.pick) begin
      if (take_a) ia_next = ia + 1'b1;
      else        jb_next = jb + 1'b1;
    end
  end

  always_comb begin
    sts.complete  = take && done_a_next && done_b_next;
    sts.has_err   = err_next != STATUS_OK;
    sts.pick_last = (take_a ? (CNT_W'(ia + 1'b1) == cnt_a && jb == cnt_b)
                            : (ia == cnt_a && CNT_W'(jb + 1'b1) == cnt_b));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a  <= '0;
      cnt_b  <= '0;
      done_a <= 1'b0;
      done_b <= 1'b0;
      err    <= STATUS_OK;
      ia     <= '0;
      jb     <= '0;
    end else if (clear) begin
      cnt_a  <= '0;
      cnt_b  <= '0;
      done_a <= 1'b0;
      done_b <= 1'b0;
      err    <= STATUS_OK;
      ia     <= '0;
      jb     <= '0;
    end else begin
      cnt_a  <= cnt_a_next;
      cnt_b  <= cnt_b_next;
      done_a <= done_a_next;
      done_b <= done_b_next;
      err    <= err_next;
      ia     <= ia_next;
      jb     <= jb_next;
    end
  end

  // first list buffer
  always_ff @(posedge clk) begin
    if (store && !in_data.list_id) begin
      buf_a[cnt_a[IDX_W-1:0]] <= value_ext;
    end
    rd_a <= buf_a[ia_next[IDX_W-1:0]];
  end

  // second list buffer
  always_ff @(posedge clk) begin
    if (store && in_data.list_id) begin
      buf_b[cnt_b[IDX_W-1:0]] <= value_ext;
    end
    rd_b <= buf_b[jb_next[IDX_W-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pick || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      out_data.merged_value <= pick_value;
      out_data.status       <= STATUS_OK;
      out_data.last         <= sts.pick_last;
    end else if (cmd.emit_err) begin
      out_data.merged_value <= '0;
      out_data.status       <= err;
      out_data.last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/two_list_sorted_merge_top.sv
// top level of the two-list sorted merge block
// joins tlsm_ctrl and tlsm_dp; uses tlsm_pkg
//
//   channel   signals                          carries
//   in        in_valid / in_ready / in_data    one list element request
//   out       out_valid / out_ready / out_data one merged element or error
//
// each element request is taken while loading, one per cycle; after both lists
// close, a prep state reads the heads, then one result per cycle leaves the output
// register while the output is not stalled (loading and merging never overlap)
// an error run gives a single result after completion, once the output is free
// a stalled output holds the merge; requests are refused during merge output
// synchronous active-high reset empties both lists and the output register
`default_nettype none

module two_list_sorted_merge_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tlsm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tlsm_pkg::out_t      out_data
);
  import tlsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign in_ready = cmd.accept_en;

  tlsm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tlsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
